/* src/hrlp_pkg.sv */
// Shared constants, types and a helper function of the HTTP request line parser.
`default_nettype none

package hrlp_pkg;

   // Limits of the request line.
   localparam int MAX_HEADER     = 2048;
   localparam int MAX_METHOD     = 10;
   localparam int MAX_URL        = 160;
   localparam int MAX_COMPONENTS = 10;
   localparam int MAX_VERSION    = 16;

   // Datapath widths.
   localparam int BC_W  = $clog2(MAX_HEADER);
   localparam int TL_W  = 8;
   localparam int CN_W  = 4;
   localparam int FO_W  = 11;
   localparam int ST_W  = 3;
   localparam int MC_W  = 3;

   // Depth of the queue between the parser and the output stage.
   localparam int QUEUE_DEPTH = 4;
   localparam int QP_W        = $clog2(QUEUE_DEPTH);

   // Status codes of the summary.
   localparam logic [ST_W-1:0] ST_OK           = 3'd0;
   localparam logic [ST_W-1:0] ST_BAD_REQUEST  = 3'd1;
   localparam logic [ST_W-1:0] ST_NOT_ALLOWED  = 3'd2;
   localparam logic [ST_W-1:0] ST_URI_TOO_LONG = 3'd3;
   localparam logic [ST_W-1:0] ST_TOO_LARGE    = 3'd4;

   // Method codes.
   localparam logic [MC_W-1:0] MC_UNKNOWN = 3'd0;

   // Characters of interest.
   localparam logic [7:0] CH_NUL   = 8'h00;
   localparam logic [7:0] CH_TAB   = 8'h09;
   localparam logic [7:0] CH_LF    = 8'h0A;
   localparam logic [7:0] CH_CR    = 8'h0D;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_SLASH = 8'h2F;
   localparam logic [7:0] CH_QMARK = 8'h3F;

   // Recognized verbs, in method code order starting at code one.
   localparam int VERB_COUNT = 7;

   localparam logic [7:0] VERB_TEXT [0:VERB_COUNT-1][0:7] = '{
      '{"G", "E", "T", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
      '{"P", "U", "T", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
      '{"P", "O", "S", "T", 8'h00, 8'h00, 8'h00, 8'h00},
      '{"D", "E", "L", "E", "T", "E", 8'h00, 8'h00},
      '{"P", "A", "T", "C", "H", 8'h00, 8'h00, 8'h00},
      '{"O", "P", "T", "I", "O", "N", "S", 8'h00},
      '{"H", "E", "A", "D", 8'h00, 8'h00, 8'h00, 8'h00}
   };

   localparam logic [3:0] VERB_LEN [0:VERB_COUNT-1] = '{
      4'd3, 4'd3, 4'd4, 4'd6, 4'd5, 4'd7, 4'd4
   };

   typedef enum logic [2:0] {
      PH_METHOD,
      PH_URL,
      PH_URL_STOP,
      PH_VERSION,
      PH_SPACE,
      PH_FIELDS,
      PH_FAIL
   } phase_type;

   // One queue entry: what one request byte produced.
   typedef struct packed {
      logic            has_rec;
      logic [CN_W-1:0] comp_index;
      logic [TL_W-1:0] comp_offset;
      logic [TL_W-1:0] comp_length;
      logic            has_sum;
      logic [ST_W-1:0] status;
      logic [MC_W-1:0] method_code;
      logic [CN_W-1:0] comp_count;
      logic [TL_W-1:0] url_length;
      logic [TL_W-1:0] path_length;
      logic            has_query;
      logic [FO_W-1:0] fields_offset;
   } entry_type;

   // One result on the output channel.
   typedef struct packed {
      logic            kind;
      logic [CN_W-1:0] comp_index;
      logic [TL_W-1:0] comp_offset;
      logic [TL_W-1:0] comp_length;
      logic [ST_W-1:0] status;
      logic [MC_W-1:0] method_code;
      logic [CN_W-1:0] comp_count;
      logic [TL_W-1:0] url_length;
      logic [TL_W-1:0] path_length;
      logic            has_query;
      logic [FO_W-1:0] fields_offset;
      logic            run_last;
   } result_type;

   // Status for a URL token that was not found, given the matched method.
   function automatic logic [ST_W-1:0] uri_status(input logic [MC_W-1:0] code);
      int start;
      start = int'(VERB_LEN[0]) + 1;
      if (code != MC_UNKNOWN) start = int'(VERB_LEN[code - 3'd1]) + 1;
      return (MAX_HEADER > MAX_URL + start) ? ST_URI_TOO_LONG : ST_BAD_REQUEST;
   endfunction

endpackage

`default_nettype wire

/* src/hrlp_ifs.sv */
// Valid/ready channel interfaces for request bytes and parse results.
`default_nettype none

interface hrlp_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       end_of_buffer;

   modport source (output valid, output data_byte, output end_of_buffer, input ready);
   modport sink   (input valid, input data_byte, input end_of_buffer, output ready);
endinterface

interface hrlp_rsp_if;
   logic                       valid;
   logic                       ready;
   logic                       kind;
   logic [hrlp_pkg::CN_W-1:0]  comp_index;
   logic [hrlp_pkg::TL_W-1:0]  comp_offset;
   logic [hrlp_pkg::TL_W-1:0]  comp_length;
   logic [hrlp_pkg::ST_W-1:0]  status;
   logic [hrlp_pkg::MC_W-1:0]  method_code;
   logic [hrlp_pkg::CN_W-1:0]  comp_count;
   logic [hrlp_pkg::TL_W-1:0]  url_length;
   logic [hrlp_pkg::TL_W-1:0]  path_length;
   logic                       has_query;
   logic [hrlp_pkg::FO_W-1:0]  fields_offset;
   logic                       run_last;

   modport source (
      output valid, output kind, output comp_index, output comp_offset,
      output comp_length, output status, output method_code, output comp_count,
      output url_length, output path_length, output has_query,
      output fields_offset, output run_last, input ready
   );
   modport sink (
      input valid, input kind, input comp_index, input comp_offset,
      input comp_length, input status, input method_code, input comp_count,
      input url_length, input path_length, input has_query,
      input fields_offset, input run_last, output ready
   );
endinterface

`default_nettype wire

/* src/hrlp_front.sv */
// Byte-wise request line parser that classifies each request and queues its results.
`default_nettype none

module hrlp_front (
   input  wire logic            clock,
   input  wire logic            reset,
   hrlp_req_if.sink             req_chan,
   input  wire logic            queue_full,
   output logic                 push,
   output hrlp_pkg::entry_type  push_entry
);

   localparam int TL_W = hrlp_pkg::TL_W;
   localparam int BC_W = hrlp_pkg::BC_W;
   localparam int CN_W = hrlp_pkg::CN_W;
   localparam int FO_W = hrlp_pkg::FO_W;
   localparam int ST_W = hrlp_pkg::ST_W;
   localparam int MC_W = hrlp_pkg::MC_W;
   localparam int VC   = hrlp_pkg::VERB_COUNT;

   hrlp_pkg::phase_type phase_ff, phase_in, phase_mid;
   logic [BC_W-1:0] byte_count_ff, byte_count_in;
   logic [TL_W-1:0] token_length_ff, token_length_in, token_length_mid;
   logic [VC-1:0]   verb_match_ff, verb_match_in, verb_match_mid;
   logic [MC_W-1:0] verb_code_ff, verb_code_in, verb_code_mid;
   logic [ST_W-1:0] parse_status_ff, parse_status_in, parse_status_mid;
   logic [CN_W-1:0] comp_number_ff, comp_number_in, comp_number_mid;
   logic [TL_W-1:0] comp_start_ff, comp_start_in, comp_start_mid;
   logic [TL_W-1:0] comp_len_ff, comp_len_in, comp_len_mid;
   logic            query_seen_ff, query_seen_in, query_seen_mid;
   logic [TL_W-1:0] query_pos_ff, query_pos_in, query_pos_mid;
   logic [TL_W-1:0] url_len_ff, url_len_in, url_len_mid;
   logic [FO_W-1:0] body_start_ff, body_start_in, body_start_mid;

   logic            accept;
   logic [7:0]      b;
   logic            eob;
   logic [TL_W-1:0] p;
   logic [TL_W:0]   p_inc;
   logic            delim;
   logic            ws;
   logic            method_over;
   logic            url_over;
   logic            version_over;
   logic            comp_last;
   logic            bc_full;
   logic [MC_W-1:0] found;
   logic [VC-1:0]   match_keep;
   logic [ST_W-1:0] uri_st;
   logic            has_rec;

   assign req_chan.ready = !queue_full;
   assign accept         = req_chan.valid && req_chan.ready;
   assign b              = req_chan.data_byte;
   assign eob            = req_chan.end_of_buffer;

   assign p            = token_length_ff;
   assign p_inc        = {1'b0, p} + 1'b1;
   assign delim        = (b == hrlp_pkg::CH_SPACE) || (b == hrlp_pkg::CH_CR) ||
                         (b == hrlp_pkg::CH_LF);
   assign ws           = (b == hrlp_pkg::CH_SPACE) ||
                         ((b >= hrlp_pkg::CH_TAB) && (b <= hrlp_pkg::CH_CR));
   assign method_over  = p_inc >= (TL_W+1)'(hrlp_pkg::MAX_METHOD);
   assign url_over     = p_inc >= (TL_W+1)'(hrlp_pkg::MAX_URL);
   assign version_over = p_inc >= (TL_W+1)'(hrlp_pkg::MAX_VERSION);
   assign comp_last    = ({1'b0, comp_number_ff} + 1'b1) >=
                         (CN_W+1)'(hrlp_pkg::MAX_COMPONENTS);
   assign bc_full      = byte_count_ff >= BC_W'(hrlp_pkg::MAX_HEADER - 1);
   assign uri_st       = hrlp_pkg::uri_status(verb_code_ff);

   // Verb candidates: a candidate survives while every byte so far matches its text.
   always_comb begin
      found      = hrlp_pkg::MC_UNKNOWN;
      match_keep = verb_match_ff;
      for (int v = 0; v < VC; v++) begin
         if (verb_match_ff[v] && (p == TL_W'(hrlp_pkg::VERB_LEN[v]))) found = MC_W'(v + 1);
         if ((p >= TL_W'(hrlp_pkg::VERB_LEN[v])) ||
             (hrlp_pkg::VERB_TEXT[v][p[2:0]] != b)) begin
            match_keep[v] = 1'b0;
         end
      end
   end

   // Next phase.
   always_comb begin
      phase_mid = phase_ff;
      unique case (phase_ff)
         hrlp_pkg::PH_METHOD: begin
            if (delim) begin
               phase_mid = ((p == '0) || (found == hrlp_pkg::MC_UNKNOWN)) ?
                           hrlp_pkg::PH_FAIL : hrlp_pkg::PH_URL;
            end else if (method_over) begin
               phase_mid = hrlp_pkg::PH_FAIL;
            end
         end
         hrlp_pkg::PH_URL, hrlp_pkg::PH_URL_STOP: begin
            if (delim) begin
               phase_mid = ((p == '0) || (parse_status_ff == hrlp_pkg::ST_TOO_LARGE)) ?
                           hrlp_pkg::PH_FAIL : hrlp_pkg::PH_VERSION;
            end else if (url_over) begin
               phase_mid = hrlp_pkg::PH_FAIL;
            end else if (phase_ff == hrlp_pkg::PH_URL) begin
               if ((b == hrlp_pkg::CH_SLASH) && (comp_len_ff != '0) && comp_last) begin
                  phase_mid = hrlp_pkg::PH_URL_STOP;
               end else if ((b == hrlp_pkg::CH_QMARK) || (b == hrlp_pkg::CH_NUL)) begin
                  phase_mid = hrlp_pkg::PH_URL_STOP;
               end
            end
         end
         hrlp_pkg::PH_VERSION: begin
            if (delim) begin
               phase_mid = (p == '0) ? hrlp_pkg::PH_FAIL : hrlp_pkg::PH_SPACE;
            end else if (version_over) begin
               phase_mid = hrlp_pkg::PH_FAIL;
            end
         end
         hrlp_pkg::PH_SPACE: begin
            if (!ws) phase_mid = hrlp_pkg::PH_FIELDS;
         end
         default: begin
            phase_mid = phase_ff;
         end
      endcase

      phase_in = phase_ff;
      if (accept) phase_in = eob ? hrlp_pkg::PH_METHOD : phase_mid;
   end

   // Token bookkeeping, component records and the end-of-buffer summary.
   always_comb begin
      token_length_mid = token_length_ff;
      verb_match_mid   = verb_match_ff;
      verb_code_mid    = verb_code_ff;
      parse_status_mid = parse_status_ff;
      comp_number_mid  = comp_number_ff;
      comp_start_mid   = comp_start_ff;
      comp_len_mid     = comp_len_ff;
      query_seen_mid   = query_seen_ff;
      query_pos_mid    = query_pos_ff;
      url_len_mid      = url_len_ff;
      body_start_mid   = body_start_ff;
      has_rec          = 1'b0;

      unique case (phase_ff)
         hrlp_pkg::PH_METHOD: begin
            if (delim) begin
               if (p == '0) begin
                  parse_status_mid = hrlp_pkg::ST_BAD_REQUEST;
               end else if (found == hrlp_pkg::MC_UNKNOWN) begin
                  parse_status_mid = hrlp_pkg::ST_NOT_ALLOWED;
               end else begin
                  verb_code_mid    = found;
                  token_length_mid = '0;
               end
            end else if (method_over) begin
               parse_status_mid = hrlp_pkg::ST_BAD_REQUEST;
            end else begin
               verb_match_mid   = match_keep;
               token_length_mid = p_inc[TL_W-1:0];
            end
         end
         hrlp_pkg::PH_URL, hrlp_pkg::PH_URL_STOP: begin
            if (delim) begin
               if (p == '0) begin
                  parse_status_mid = uri_st;
               end else if (parse_status_ff == hrlp_pkg::ST_TOO_LARGE) begin
                  parse_status_mid = hrlp_pkg::ST_TOO_LARGE;
               end else begin
                  url_len_mid      = p;
                  has_rec          = (phase_ff == hrlp_pkg::PH_URL) && (comp_len_ff != '0);
                  token_length_mid = '0;
               end
            end else if (url_over) begin
               parse_status_mid = uri_st;
            end else begin
               if (phase_ff == hrlp_pkg::PH_URL) begin
                  if (b == hrlp_pkg::CH_SLASH) begin
                     if (comp_len_ff != '0) begin
                        has_rec         = 1'b1;
                        comp_number_mid = comp_number_ff + 1'b1;
                        if (comp_last) begin
                           parse_status_mid = hrlp_pkg::ST_TOO_LARGE;
                        end else begin
                           comp_start_mid = p_inc[TL_W-1:0];
                           comp_len_mid   = '0;
                        end
                     end else begin
                        comp_start_mid = p_inc[TL_W-1:0];
                     end
                  end else if (b == hrlp_pkg::CH_QMARK) begin
                     query_seen_mid = 1'b1;
                     query_pos_mid  = p;
                  end else if (b != hrlp_pkg::CH_NUL) begin
                     comp_len_mid = comp_len_ff + 1'b1;
                  end
               end
               token_length_mid = p_inc[TL_W-1:0];
            end
         end
         hrlp_pkg::PH_VERSION: begin
            if (delim) begin
               if (p == '0) parse_status_mid = hrlp_pkg::ST_BAD_REQUEST;
            end else if (version_over) begin
               parse_status_mid = hrlp_pkg::ST_BAD_REQUEST;
            end else begin
               token_length_mid = p_inc[TL_W-1:0];
            end
         end
         hrlp_pkg::PH_SPACE: begin
            if (!ws) body_start_mid = FO_W'(byte_count_ff);
         end
         default: begin
            has_rec = 1'b0;
         end
      endcase

      // The record carries the component as it stood before this byte.
      push_entry             = '0;
      push_entry.has_rec     = has_rec;
      push_entry.comp_index  = comp_number_ff;
      push_entry.comp_offset = comp_start_ff;
      push_entry.comp_length = comp_len_ff;
      push_entry.has_sum     = eob;
      push_entry.method_code = verb_code_mid;

      if (bc_full) begin
         push_entry.status      = hrlp_pkg::ST_TOO_LARGE;
         push_entry.method_code = hrlp_pkg::MC_UNKNOWN;
      end else if (phase_mid == hrlp_pkg::PH_SPACE) begin
         push_entry.status        = hrlp_pkg::ST_OK;
         push_entry.fields_offset = FO_W'({1'b0, byte_count_ff} + 1'b1);
      end else if (phase_mid == hrlp_pkg::PH_FIELDS) begin
         push_entry.status        = hrlp_pkg::ST_OK;
         push_entry.fields_offset = body_start_mid;
      end else if (phase_mid == hrlp_pkg::PH_FAIL) begin
         push_entry.status = parse_status_mid;
      end else if ((phase_mid == hrlp_pkg::PH_URL) || (phase_mid == hrlp_pkg::PH_URL_STOP)) begin
         push_entry.status = hrlp_pkg::uri_status(verb_code_mid);
      end else begin
         push_entry.status = hrlp_pkg::ST_BAD_REQUEST;
      end

      if (push_entry.status == hrlp_pkg::ST_OK) begin
         push_entry.comp_count  = comp_number_mid + CN_W'(comp_len_mid != '0);
         push_entry.url_length  = url_len_mid;
         push_entry.path_length = query_seen_mid ? query_pos_mid : url_len_mid;
         push_entry.has_query   = query_seen_mid;
      end else begin
         push_entry.fields_offset = '0;
      end

      push = accept && (has_rec || eob);

      // A new buffer starts from the reset state.
      token_length_in = token_length_ff;
      verb_match_in   = verb_match_ff;
      verb_code_in    = verb_code_ff;
      parse_status_in = parse_status_ff;
      comp_number_in  = comp_number_ff;
      comp_start_in   = comp_start_ff;
      comp_len_in     = comp_len_ff;
      query_seen_in   = query_seen_ff;
      query_pos_in    = query_pos_ff;
      url_len_in      = url_len_ff;
      body_start_in   = body_start_ff;
      byte_count_in   = byte_count_ff;
      if (accept) begin
         if (eob) begin
            token_length_in = '0;
            verb_match_in   = '1;
            verb_code_in    = hrlp_pkg::MC_UNKNOWN;
            parse_status_in = hrlp_pkg::ST_BAD_REQUEST;
            comp_number_in  = '0;
            comp_start_in   = '0;
            comp_len_in     = '0;
            query_seen_in   = 1'b0;
            query_pos_in    = '0;
            url_len_in      = '0;
            body_start_in   = '0;
            byte_count_in   = '0;
         end else begin
            token_length_in = token_length_mid;
            verb_match_in   = verb_match_mid;
            verb_code_in    = verb_code_mid;
            parse_status_in = parse_status_mid;
            comp_number_in  = comp_number_mid;
            comp_start_in   = comp_start_mid;
            comp_len_in     = comp_len_mid;
            query_seen_in   = query_seen_mid;
            query_pos_in    = query_pos_mid;
            url_len_in      = url_len_mid;
            body_start_in   = body_start_mid;
            if (!bc_full) byte_count_in = byte_count_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff        <= hrlp_pkg::PH_METHOD;
         byte_count_ff   <= '0;
         token_length_ff <= '0;
         verb_match_ff   <= '1;
         verb_code_ff    <= hrlp_pkg::MC_UNKNOWN;
         parse_status_ff <= hrlp_pkg::ST_BAD_REQUEST;
         comp_number_ff  <= '0;
         comp_start_ff   <= '0;
         comp_len_ff     <= '0;
         query_seen_ff   <= 1'b0;
         query_pos_ff    <= '0;
         url_len_ff      <= '0;
         body_start_ff   <= '0;
      end else begin
         phase_ff        <= phase_in;
         byte_count_ff   <= byte_count_in;
         token_length_ff <= token_length_in;
         verb_match_ff   <= verb_match_in;
         verb_code_ff    <= verb_code_in;
         parse_status_ff <= parse_status_in;
         comp_number_ff  <= comp_number_in;
         comp_start_ff   <= comp_start_in;
         comp_len_ff     <= comp_len_in;
         query_seen_ff   <= query_seen_in;
         query_pos_ff    <= query_pos_in;
         url_len_ff      <= url_len_in;
         body_start_ff   <= body_start_in;
      end
   end

   a_eob_restarts: assert property (@(posedge clock) disable iff (reset)
      accept && eob |=> (phase_ff == hrlp_pkg::PH_METHOD) && (byte_count_ff == '0) &&
                        (comp_number_ff == '0))
      else $error("parser state not restarted after the last byte of a buffer");

   a_fail_has_status: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == hrlp_pkg::PH_FAIL) |-> (parse_status_ff != hrlp_pkg::ST_OK))
      else $error("failed parse carries an ok status");

endmodule

`default_nettype wire

/* src/hrlp_queue.sv */
// Small queue that decouples the parser from the result output stage.
`default_nettype none

module hrlp_queue (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                push,
   input  wire hrlp_pkg::entry_type push_entry,
   output logic                     full,
   input  wire logic                pop,
   output hrlp_pkg::entry_type      head,
   output logic                     empty
);

   localparam int QP_W  = hrlp_pkg::QP_W;
   localparam int DEPTH = hrlp_pkg::QUEUE_DEPTH;

   hrlp_pkg::entry_type slot_ff [DEPTH];
   logic [QP_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QP_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QP_W:0]   count_ff, count_in;
   logic            do_push;
   logic            do_pop;

   assign full    = count_ff == (QP_W+1)'(DEPTH);
   assign empty   = count_ff == '0;
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign head    = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff + (QP_W+1)'(do_push) - (QP_W+1)'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) slot_ff[wr_ptr_ff] <= push_entry;
   end

   a_no_push_when_full: assert property (@(posedge clock) disable iff (reset)
      push |-> !full)
      else $error("entry pushed into a full queue");

   a_count_tracks_pointers: assert property (@(posedge clock) disable iff (reset)
      (count_ff <= (QP_W+1)'(DEPTH)) &&
      (wr_ptr_ff == (rd_ptr_ff + count_ff[QP_W-1:0])))
      else $error("queue count out of step with its pointers");

endmodule

`default_nettype wire

/* src/hrlp_back.sv */
// Output stage that turns queue entries into component records and summaries.
`default_nettype none

module hrlp_back (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire hrlp_pkg::entry_type head,
   input  wire logic                empty,
   output logic                     pop,
   hrlp_rsp_if.source               rsp_chan
);

   hrlp_pkg::result_type res_ff, res_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic second_ff, second_in;
   logic load;
   logic emit_rec;

   // The output register reloads from a non-empty queue whenever it is empty or being taken.
   assign load     = !empty && (!rsp_valid_ff || rsp_chan.ready);
   assign emit_rec = head.has_rec && !second_ff;

   always_comb begin
      res_in       = res_ff;
      second_in    = second_ff;
      pop          = 1'b0;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      if (load) begin
         rsp_valid_in = 1'b1;
         res_in       = '0;
         if (emit_rec) begin
            res_in.kind        = 1'b0;
            res_in.comp_index  = head.comp_index;
            res_in.comp_offset = head.comp_offset;
            res_in.comp_length = head.comp_length;
            res_in.run_last    = !head.has_sum;
            second_in          = head.has_sum;
            pop                = !head.has_sum;
         end else begin
            res_in.kind          = 1'b1;
            res_in.status        = head.status;
            res_in.method_code   = head.method_code;
            res_in.comp_count    = head.comp_count;
            res_in.url_length    = head.url_length;
            res_in.path_length   = head.path_length;
            res_in.has_query     = head.has_query;
            res_in.fields_offset = head.fields_offset;
            res_in.run_last      = 1'b1;
            second_in            = 1'b0;
            pop                  = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         second_ff    <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         second_ff    <= second_in;
      end
   end

   always_ff @(posedge clock) begin
      res_ff <= res_in;
   end

   assign rsp_chan.valid         = rsp_valid_ff;
   assign rsp_chan.kind          = res_ff.kind;
   assign rsp_chan.comp_index    = res_ff.comp_index;
   assign rsp_chan.comp_offset   = res_ff.comp_offset;
   assign rsp_chan.comp_length   = res_ff.comp_length;
   assign rsp_chan.status        = res_ff.status;
   assign rsp_chan.method_code   = res_ff.method_code;
   assign rsp_chan.comp_count    = res_ff.comp_count;
   assign rsp_chan.url_length    = res_ff.url_length;
   assign rsp_chan.path_length   = res_ff.path_length;
   assign rsp_chan.has_query     = res_ff.has_query;
   assign rsp_chan.fields_offset = res_ff.fields_offset;
   assign rsp_chan.run_last      = res_ff.run_last;

   a_second_half_pending: assert property (@(posedge clock) disable iff (reset)
      second_ff |-> !empty && head.has_rec && head.has_sum)
      else $error("summary pending without a matching queue entry");

   a_record_not_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !res_ff.kind |-> (res_ff.comp_length != '0) &&
                                       (res_ff.run_last == !second_ff))
      else $error("component record malformed or run_last out of step");

endmodule

`default_nettype wire

/* src/http_request_line_parser_unit.sv */
// Top level of the HTTP request line parser.
`default_nettype none

// Takes one header byte per request on req_chan and reports on rsp_chan a
// record for every non-empty path component that closes before the first '?'
// or NUL, plus a summary (status, method, counts, offsets) for the byte
// marked end_of_buffer. The parser accepts one byte every clock; a byte
// produces at most two results, which the output register hands out one per
// clock while rsp_chan is ready, so only a byte that both closes a component
// and ends the buffer gives two results. A four-entry queue between the
// parser and the output register absorbs output stalls; bytes stall only
// when it fills. The results of a byte pass through the queue and then the
// output register. No clearing pass follows reset.
module http_request_line_parser_unit (
   input  wire logic  clock,
   input  wire logic  reset,
   hrlp_req_if.sink   req_chan,
   hrlp_rsp_if.source rsp_chan
);

   logic                queue_full;
   logic                queue_empty;
   logic                push;
   logic                pop;
   hrlp_pkg::entry_type push_entry;
   hrlp_pkg::entry_type head;

   hrlp_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_chan   (req_chan),
      .queue_full (queue_full),
      .push       (push),
      .push_entry (push_entry)
   );

   hrlp_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .full       (queue_full),
      .pop        (pop),
      .head       (head),
      .empty      (queue_empty)
   );

   hrlp_back u_back (
      .clock    (clock),
      .reset    (reset),
      .head     (head),
      .empty    (queue_empty),
      .pop      (pop),
      .rsp_chan (rsp_chan)
   );

endmodule

`default_nettype wire
